// File: rtl/core/lsqaq_pkg.sv
// Shared types, widths and codes for the LSQ activation quantizer.
package lsqaq_pkg;

	// Field formats
	localparam int DATA_W    = 16;              // activation and gradient, signed Q8.8
	localparam int FRAC_BITS = 8;
	localparam int LVL_W     = 8;
	localparam int STEP_W    = 16;
	localparam int SCALE_W   = 16;
	localparam int ACC_W     = 48;              // accumulator, 2*FRAC_BITS fraction bits
	localparam int SG_W      = 40;              // step gradient, 24 fraction bits
	localparam int SG_FRAC   = 24;

	// Serial units
	localparam int DIV_W  = STEP_W + 1;         // divider operand width (divisor up to 2*step)
	localparam int MUL_W  = SCALE_W;            // multiplier operand width
	localparam int PROD_W = ACC_W + MUL_W;
	localparam int CNT_W  = $clog2(DIV_W + 1);

	// Config port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GRAD_SCALE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ACC_PREV   = 2'd3;

	localparam logic OP_FORWARD  = 1'b0;
	localparam logic OP_BACKWARD = 1'b1;

	typedef struct packed {
		logic                     operation;
		logic signed [DATA_W-1:0] activation;
		logic signed [DATA_W-1:0] upstream_grad;
		logic                     last;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value_out;
		logic [LVL_W-1:0]         level;
		logic signed [SG_W-1:0]   step_grad;
		logic                     step_grad_valid;
		logic                     last_out;
	} result_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] count;
		logic [DIV_W-1:0] init_rem;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
		logic [DIV_W-1:0] rem;
	} div_rsp_t;

	typedef struct packed {
		logic                    start;
		logic [CNT_W-1:0]        count;
		logic signed [ACC_W-1:0] mcand;
		logic [MUL_W-1:0]        mplier;
	} mul_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [PROD_W-1:0] prod;
	} mul_rsp_t;

endpackage

// File: rtl/core/lsqaq_div.sv
// Restoring divider, one quotient bit per cycle.
module lsqaq_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lsqaq_pkg::div_req_t  req,
	output lsqaq_pkg::div_rsp_t  rsp
);

	logic [lsqaq_pkg::CNT_W-1:0] cnt_q;
	logic                        done_q;
	logic [lsqaq_pkg::DIV_W-1:0] rem_q;
	logic [lsqaq_pkg::DIV_W-1:0] dvd_q;
	logic [lsqaq_pkg::DIV_W-1:0] dsr_q;
	logic [lsqaq_pkg::DIV_W-1:0] quot_q;
	logic [lsqaq_pkg::DIV_W:0]   shifted;
	logic [lsqaq_pkg::DIV_W:0]   trial;

	// partial remainder stays below the divisor, so the trial sign is bit DIV_W
	assign shifted = {rem_q, dvd_q[lsqaq_pkg::DIV_W-1]};
	assign trial   = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			if (req.start) begin
				cnt_q <= req.count;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
			done_q <= !req.start && (cnt_q == lsqaq_pkg::CNT_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.init_rem;
			dvd_q  <= req.dividend;
			dsr_q  <= req.divisor;
			quot_q <= '0;
		end else if (cnt_q != '0) begin
			if (!trial[lsqaq_pkg::DIV_W]) begin
				rem_q  <= trial[lsqaq_pkg::DIV_W-1:0];
				quot_q <= {quot_q[lsqaq_pkg::DIV_W-2:0], 1'b1};
			end else begin
				rem_q  <= shifted[lsqaq_pkg::DIV_W-1:0];
				quot_q <= {quot_q[lsqaq_pkg::DIV_W-2:0], 1'b0};
			end
			dvd_q <= {dvd_q[lsqaq_pkg::DIV_W-2:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;

endmodule

// File: rtl/core/lsqaq_mul.sv
// Shift-add multiplier, signed multiplicand, one multiplier bit per cycle from the MSB.
module lsqaq_mul (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lsqaq_pkg::mul_req_t  req,
	output lsqaq_pkg::mul_rsp_t  rsp
);

	logic [lsqaq_pkg::CNT_W-1:0]  cnt_q;
	logic                         done_q;
	logic [lsqaq_pkg::PROD_W-1:0] p_q;
	logic [lsqaq_pkg::ACC_W-1:0]  mc_q;
	logic [lsqaq_pkg::MUL_W-1:0]  mp_q;
	logic [lsqaq_pkg::PROD_W-1:0] addend;

	assign addend = mp_q[lsqaq_pkg::MUL_W-1] ?
		{{(lsqaq_pkg::PROD_W-lsqaq_pkg::ACC_W){mc_q[lsqaq_pkg::ACC_W-1]}}, mc_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			if (req.start) begin
				cnt_q <= req.count;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
			done_q <= !req.start && (cnt_q == lsqaq_pkg::CNT_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			p_q  <= '0;
			mc_q <= req.mcand;
			mp_q <= req.mplier;
		end else if (cnt_q != '0) begin
			p_q  <= {p_q[lsqaq_pkg::PROD_W-2:0], 1'b0} + addend;
			mp_q <= {mp_q[lsqaq_pkg::MUL_W-2:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = p_q;

endmodule

// File: rtl/core/lsq_activation_quantizer_core.sv
// LSQ activation quantizer: forward quantize, backward gradient pass and step-size gradient.
//
// One word at a time. A word with a non-positive activation skips the divider. Otherwise
// the serial divider computes (2a+s)/(2s), which gives the level and the region; a
// forward word then multiplies level*step. A backward word above the range multiplies
// max_level*grad; inside the range it runs a divide for the quantization error and a
// multiply by the gradient. The last backward word of a tensor adds the 16-bit
// grad_scale multiply. A finished word waits in the output register and does not hold
// up the next input word. Configuration is written through cfg_write/cfg_index/cfg_data
// with the block idle; step_size 0 acts as 1.

module lsq_activation_quantizer_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  lsqaq_pkg::item_t                    item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output lsqaq_pkg::result_t                  result,
	input  logic                                cfg_write,
	input  logic [lsqaq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lsqaq_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int DATA_W    = lsqaq_pkg::DATA_W;
	localparam int FRAC_BITS = lsqaq_pkg::FRAC_BITS;
	localparam int LVL_W     = lsqaq_pkg::LVL_W;
	localparam int STEP_W    = lsqaq_pkg::STEP_W;
	localparam int SCALE_W   = lsqaq_pkg::SCALE_W;
	localparam int ACC_W     = lsqaq_pkg::ACC_W;
	localparam int SG_W      = lsqaq_pkg::SG_W;
	localparam int DIV_W     = lsqaq_pkg::DIV_W;
	localparam int MUL_W     = lsqaq_pkg::MUL_W;
	localparam int PROD_W    = lsqaq_pkg::PROD_W;
	localparam int CNT_W     = lsqaq_pkg::CNT_W;

	// stored step gradient (24 frac) down to accumulator format (2*FRAC_BITS frac)
	localparam int ALIGN_SH = lsqaq_pkg::SG_FRAC - 2 * FRAC_BITS;
	// sum * grad_scale has 2*FRAC_BITS+16 frac bits, result has 24
	localparam int SCALE_SH = 2 * FRAC_BITS + SCALE_W - lsqaq_pkg::SG_FRAC;
	localparam logic [PROD_W-1:0] ROUND_ADD = PROD_W'(1) << (SCALE_SH - 1);

	localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [SG_W-1:0]   SG_MAX   = {1'b0, {(SG_W-1){1'b1}}};
	localparam logic [SG_W-1:0]   SG_MIN   = {1'b1, {(SG_W-1){1'b0}}};

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV1 = 3'd1;  // level divide
	localparam logic [2:0] S_DIV2 = 3'd2;  // quantization error divide
	localparam logic [2:0] S_MULF = 3'd3;  // level * step
	localparam logic [2:0] S_MULC = 3'd4;  // gradient contribution
	localparam logic [2:0] S_LAST = 3'd5;  // fold in previous, start scale multiply
	localparam logic [2:0] S_MULG = 3'd6;  // sum * grad_scale
	localparam logic [2:0] S_OUT  = 3'd7;  // hand word to output register

	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] x);
		if (x[ACC_W] != x[ACC_W-1]) begin
			return x[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end
		return x[ACC_W-1:0];
	endfunction

	// config registers
	logic [LVL_W-1:0]   max_level_q;
	logic [STEP_W-1:0]  step_size_q;
	logic [SCALE_W-1:0] grad_scale_q;
	logic               acc_prev_q;

	// control and state
	logic [2:0]              state_q;
	logic                    result_valid_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [SG_W-1:0]  stored_q;

	// word in flight
	logic                     op_q;
	logic signed [DATA_W-1:0] g_q;
	logic                     last_q;
	logic                     e_neg_q;
	logic                     c_shift_q;
	logic signed [DATA_W-1:0] val_q;
	logic [LVL_W-1:0]         lvl_q;
	logic signed [SG_W-1:0]   sg_q;
	logic                     sgv_q;
	lsqaq_pkg::result_t       result_q;

	// serial units
	lsqaq_pkg::div_req_t div_req;
	lsqaq_pkg::div_rsp_t div_rsp;
	lsqaq_pkg::mul_req_t mul_req;
	lsqaq_pkg::mul_rsp_t mul_rsp;

	logic                     item_acc;
	logic                     a_pos;
	logic [STEP_W-1:0]        s_eff;
	logic [DIV_W-1:0]         s_ext;
	logic [DIV_W-1:0]         m_ext;
	logic [DIV_W-1:0]         div1_num;
	logic                     above;
	logic [LVL_W-1:0]         lvl_sel;
	logic                     d_neg;
	logic [DIV_W-1:0]         d_diff;
	logic [DIV_W-1:0]         d_mag;
	logic signed [ACC_W-1:0]  g_wide;
	logic signed [ACC_W:0]    c_wide;
	logic signed [ACC_W:0]    acc_sum;
	logic signed [ACC_W:0]    prev_ext;
	logic signed [ACC_W-1:0]  total;
	logic [PROD_W-1:0]        rounded;
	logic                     sg_fits;
	logic [SG_W-1:0]          sg_sel;
	logic [DATA_W-1:0]        fwd_sat;

	assign item_stall   = (state_q != S_IDLE);
	assign item_acc     = item_valid && !item_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign s_eff = (step_size_q == '0) ? STEP_W'(1) : step_size_q;
	assign s_ext = DIV_W'(s_eff);
	assign m_ext = DIV_W'(max_level_q);

	assign a_pos    = !item.activation[DATA_W-1] && (item.activation != '0);
	assign div1_num = DIV_W'({item.activation[DATA_W-2:0], 1'b0}) + s_ext;

	// 2a+s = r*2s + rem; a >= m*s exactly when r > m, or r == m and rem >= s
	assign above   = (div_rsp.quot > m_ext) || ((div_rsp.quot == m_ext) && (div_rsp.rem >= s_ext));
	assign lvl_sel = above ? max_level_q : div_rsp.quot[LVL_W-1:0];

	// r*s - a = (s - rem)/2, exact since rem and s share parity
	assign d_neg  = div_rsp.rem > s_ext;
	assign d_diff = d_neg ? (div_rsp.rem - s_ext) : (s_ext - div_rsp.rem);
	assign d_mag  = d_diff >> 1;

	assign g_wide = ACC_W'(g_q);

	// gradient contribution and saturating accumulate
	assign c_wide  = c_shift_q ? ((ACC_W+1)'(mul_rsp.prod) <<< FRAC_BITS)
	                           : (ACC_W+1)'(mul_rsp.prod);
	assign acc_sum = (ACC_W+1)'(acc_q) + c_wide;

	assign prev_ext = (ACC_W+1)'(stored_q >>> ALIGN_SH);
	assign total    = acc_prev_q ? sat_acc((ACC_W+1)'(acc_q) + prev_ext) : acc_q;

	// scaled result: round half up, then saturate to SG_W
	assign rounded = mul_rsp.prod + ROUND_ADD;
	assign sg_fits = (rounded[PROD_W-1:SCALE_SH+SG_W-1] == '0) ||
	                 (rounded[PROD_W-1:SCALE_SH+SG_W-1] == '1);
	assign sg_sel  = sg_fits ? rounded[SCALE_SH+SG_W-1:SCALE_SH]
	                         : (rounded[PROD_W-1] ? SG_MIN : SG_MAX);

	// forward product is non-negative
	assign fwd_sat = (mul_rsp.prod[PROD_W-1:DATA_W-1] != '0) ? DATA_MAX
	                                                         : mul_rsp.prod[DATA_W-1:0];

	// divider requests
	always_comb begin
		div_req = '0;
		if ((state_q == S_IDLE) && item_acc && a_pos) begin
			div_req.start    = 1'b1;
			div_req.count    = CNT_W'(DIV_W);
			div_req.init_rem = '0;
			div_req.dividend = div1_num;
			div_req.divisor  = {s_eff, 1'b0};
		end else if ((state_q == S_DIV1) && div_rsp.done &&
		             (op_q == lsqaq_pkg::OP_BACKWARD) && !above) begin
			// error = (|d| << FRAC_BITS) / s, at most 2^(FRAC_BITS-1)
			div_req.start    = 1'b1;
			div_req.count    = CNT_W'(FRAC_BITS);
			div_req.init_rem = d_mag;
			div_req.dividend = '0;
			div_req.divisor  = s_ext;
		end
	end

	// multiplier requests
	always_comb begin
		mul_req = '0;
		case (state_q)
			S_DIV1: begin
				if (div_rsp.done) begin
					if (op_q == lsqaq_pkg::OP_FORWARD) begin
						mul_req.start  = 1'b1;
						mul_req.count  = CNT_W'(LVL_W);
						mul_req.mcand  = ACC_W'(s_eff);
						mul_req.mplier = MUL_W'(lvl_sel) << (MUL_W - LVL_W);
					end else if (above) begin
						mul_req.start  = 1'b1;
						mul_req.count  = CNT_W'(LVL_W);
						mul_req.mcand  = g_wide;
						mul_req.mplier = MUL_W'(max_level_q) << (MUL_W - LVL_W);
					end
				end
			end
			S_DIV2: begin
				if (div_rsp.done) begin
					mul_req.start  = 1'b1;
					mul_req.count  = CNT_W'(FRAC_BITS);
					mul_req.mcand  = e_neg_q ? -g_wide : g_wide;
					mul_req.mplier = MUL_W'(div_rsp.quot[FRAC_BITS-1:0]) << (MUL_W - FRAC_BITS);
				end
			end
			S_LAST: begin
				mul_req.start  = 1'b1;
				mul_req.count  = CNT_W'(MUL_W);
				mul_req.mcand  = total;
				mul_req.mplier = grad_scale_q;
			end
			default: begin
			end
		endcase
	end

	lsqaq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	lsqaq_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	// config, sequencer, accumulator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_level_q    <= 8'd255;
			step_size_q    <= 16'd256;
			grad_scale_q   <= 16'd4096;
			acc_prev_q     <= 1'b0;
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
			acc_q          <= '0;
			stored_q       <= '0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					lsqaq_pkg::REG_MAX_LEVEL:  max_level_q  <= cfg_data[LVL_W-1:0];
					lsqaq_pkg::REG_STEP_SIZE:  step_size_q  <= cfg_data[STEP_W-1:0];
					lsqaq_pkg::REG_GRAD_SCALE: grad_scale_q <= cfg_data[SCALE_W-1:0];
					lsqaq_pkg::REG_ACC_PREV:   acc_prev_q   <= cfg_data[0];
					default: begin
					end
				endcase
			end

			// output register: load a finished word, or empty it once taken
			if ((state_q == S_OUT) && (!result_valid_q || !result_stall)) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (item_acc) begin
						if (a_pos) begin
							state_q <= S_DIV1;
						end else if ((item.operation == lsqaq_pkg::OP_BACKWARD) && item.last) begin
							state_q <= S_LAST;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_DIV1: begin
					if (div_rsp.done) begin
						if (op_q == lsqaq_pkg::OP_FORWARD) begin
							state_q <= S_MULF;
						end else if (above) begin
							state_q <= S_MULC;
						end else begin
							state_q <= S_DIV2;
						end
					end
				end
				S_DIV2: begin
					if (div_rsp.done) begin
						state_q <= S_MULC;
					end
				end
				S_MULF: begin
					if (mul_rsp.done) begin
						state_q <= S_OUT;
					end
				end
				S_MULC: begin
					if (mul_rsp.done) begin
						acc_q   <= sat_acc(acc_sum);
						state_q <= last_q ? S_LAST : S_OUT;
					end
				end
				S_LAST: begin
					// sum already captured by the multiplier; start the next tensor clean
					acc_q   <= '0;
					state_q <= S_MULG;
				end
				S_MULG: begin
					if (mul_rsp.done) begin
						stored_q <= sg_sel;
						state_q  <= S_OUT;
					end
				end
				S_OUT: begin
					if (!result_valid_q || !result_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// word datapath
	always_ff @(posedge clk) begin
		if (item_acc) begin
			op_q   <= item.operation;
			g_q    <= item.upstream_grad;
			last_q <= item.last;
			val_q  <= '0;
			lvl_q  <= '0;
			sg_q   <= '0;
			sgv_q  <= 1'b0;
		end
		if ((state_q == S_DIV1) && div_rsp.done) begin
			if (op_q == lsqaq_pkg::OP_FORWARD) begin
				lvl_q <= lvl_sel;
			end else begin
				val_q     <= above ? '0 : g_q;
				c_shift_q <= above;
				e_neg_q   <= d_neg;
			end
		end
		if ((state_q == S_MULF) && mul_rsp.done) begin
			val_q <= fwd_sat;
		end
		if ((state_q == S_MULG) && mul_rsp.done) begin
			sg_q  <= sg_sel;
			sgv_q <= 1'b1;
		end
		if ((state_q == S_OUT) && (!result_valid_q || !result_stall)) begin
			result_q.value_out       <= val_q;
			result_q.level           <= lvl_q;
			result_q.step_grad       <= sg_q;
			result_q.step_grad_valid <= sgv_q;
			result_q.last_out        <= last_q;
		end
	end

endmodule

// File: rtl/core/lsqaq_checker.sv
// Port-level checks for the LSQ activation quantizer, bound to lsq_activation_quantizer_core.
module lsqaq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_stall,
	input logic               result_valid,
	input logic               result_stall,
	input lsqaq_pkg::result_t result
);

	// a stalled result word holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	// every accepted word moves the sequencer out of idle, so an accept leaves the input stalled
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("input not stalled after accept");

	// step gradient only comes with the last backward word
	a_sg_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.step_grad_valid |-> result.last_out && (result.level == '0))
		else $error("step gradient on a non-last or forward word");

	a_sg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.step_grad_valid |-> (result.step_grad == '0))
		else $error("step gradient nonzero without valid flag");

	// forward quantized values are never negative
	a_fwd_sign: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.level != '0) |-> !result.value_out[lsqaq_pkg::DATA_W-1])
		else $error("negative quantized value");

endmodule

bind lsq_activation_quantizer_core lsqaq_checker u_lsqaq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
